[rtl/flwc_pkg.sv]
// ----------------------------------------------------------------------------
// flwc_pkg
// Shared constants, state codes and the memory request bundle of the
// fixed-length walk counter.
// ----------------------------------------------------------------------------
package flwc_pkg;

  localparam int MAX_NODES = 32;
  localparam int NODE_W    = 5;
  localparam int STEPS_W   = 6;
  localparam int COUNT_W   = 64;
  localparam int SUCC_W    = 2 * NODE_W;
  localparam int CADDR_W   = NODE_W + 1;
  localparam int CDEPTH    = 2 * MAX_NODES;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_DRAIN,
    ST_READ,
    ST_CAPT
  } flwc_state_t;

  typedef struct packed {
    logic                succ_we;
    logic [NODE_W-1:0]   succ_waddr;
    logic [SUCC_W-1:0]   succ_wdata;
    logic [NODE_W-1:0]   succ_raddr;
    logic                cnt_we;
    logic [CADDR_W-1:0]  cnt_waddr;
    logic                cnt_init;
    logic                init_bit;
    logic [CADDR_W-1:0]  cnt_ra0;
    logic [CADDR_W-1:0]  cnt_ra1;
    logic                use0;
    logic                use1;
    logic                capture;
  } flwc_cmd_t;

endpackage

[rtl/flwc_if.sv]
// ----------------------------------------------------------------------------
// flwc_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface flwc_in_if import flwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [NODE_W-1:0]  node;
  logic [NODE_W-1:0]  next_yes;
  logic [NODE_W-1:0]  next_no;
  logic               target;
  logic [STEPS_W-1:0] steps;

  modport source (output valid, mode, node, next_yes, next_no, target, steps,
                  input ready);
  modport sink   (input valid, mode, node, next_yes, next_no, target, steps,
                  output ready);
endinterface

interface flwc_out_if import flwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] walk_count;

  modport source (output valid, walk_count, input ready);
  modport sink   (input valid, walk_count, output ready);
endinterface

[rtl/flwc_ram.sv]
// ----------------------------------------------------------------------------
// flwc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module flwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra0,
  input  logic [$clog2(DEPTH)-1:0] ra1,
  output logic [WIDTH-1:0]         rd0,
  output logic [WIDTH-1:0]         rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

[rtl/flwc_ctrl.sv]
// ----------------------------------------------------------------------------
// flwc_ctrl
// Sequencer: node loads, count bank initialisation, per-step sweep through
// the node table with a two-stage read pipeline, drain and result fetch.
// ----------------------------------------------------------------------------
module flwc_ctrl import flwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  flwc_in_if.sink           in_chan,
  input  logic [SUCC_W-1:0] succ_rdata,
  input  logic              out_busy,
  output flwc_cmd_t         cmd
);

  flwc_state_t          state_r, state_nxt;
  logic [NODE_W-1:0]    v_r, v_nxt;
  logic [STEPS_W-1:0]   steps_r, steps_nxt;
  logic                 cur_r, cur_nxt;
  logic                 s1_valid_r, s2_valid_r;
  logic [NODE_W-1:0]    s1_node_r, s2_node_r;
  logic                 s2_use0_r, s2_use1_r;
  logic [MAX_NODES-1:0] tgt_r, tgt_nxt;
  logic                 issue;
  logic                 accept;
  logic [NODE_W-1:0]    succ_yes, succ_no;
  logic                 yes_ok, no_ok;

  assign succ_yes = succ_rdata[SUCC_W-1:NODE_W];
  assign succ_no  = succ_rdata[NODE_W-1:0];
  assign yes_ok   = 32'(succ_yes) < MAX_NODES;
  assign no_ok    = 32'(succ_no) < MAX_NODES;
  assign accept   = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      v_r        <= '0;
      steps_r    <= '0;
      cur_r      <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      tgt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      v_r        <= v_nxt;
      steps_r    <= steps_nxt;
      cur_r      <= cur_nxt;
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      tgt_r      <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_node_r <= v_r;
    s2_node_r <= s1_node_r;
    s2_use0_r <= yes_ok;
    s2_use1_r <= no_ok;
  end

  always_comb begin
    state_nxt      = state_r;
    v_nxt          = v_r;
    steps_nxt      = steps_r;
    cur_nxt        = cur_r;
    tgt_nxt        = tgt_r;
    issue          = 1'b0;
    in_chan.ready  = 1'b0;

    cmd            = '0;
    cmd.succ_waddr = in_chan.node;
    cmd.succ_wdata = {in_chan.next_yes, in_chan.next_no};
    cmd.succ_raddr = v_r;
    cmd.cnt_ra0    = s1_valid_r ? {cur_r, succ_yes} : {cur_r, NODE_W'(0)};
    cmd.cnt_ra1    = {cur_r, succ_no};
    cmd.use0       = s2_use0_r;
    cmd.use1       = s2_use1_r;
    cmd.cnt_we     = s2_valid_r;
    cmd.cnt_waddr  = {~cur_r, s2_node_r};
    cmd.init_bit   = tgt_r[v_r];

    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (accept) begin
          if (in_chan.mode == MODE_LOAD) begin
            if (32'(in_chan.node) < MAX_NODES) begin
              cmd.succ_we            = 1'b1;
              tgt_nxt[in_chan.node]  = in_chan.target;
            end
          end else begin
            steps_nxt = in_chan.steps;
            v_nxt     = '0;
            cur_nxt   = 1'b0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.cnt_we    = 1'b1;
        cmd.cnt_init  = 1'b1;
        cmd.cnt_waddr = {1'b0, v_r};
        v_nxt         = v_r + 1'b1;
        if (32'(v_r) == MAX_NODES - 1) begin
          v_nxt     = '0;
          state_nxt = (steps_r == '0) ? ST_READ : ST_STEP;
        end
      end
      ST_STEP: begin
        issue = 1'b1;
        v_nxt = v_r + 1'b1;
        if (32'(v_r) == MAX_NODES - 1) begin
          v_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_r && !s2_valid_r) begin
          cur_nxt   = ~cur_r;
          steps_nxt = steps_r - 1'b1;
          state_nxt = (steps_r == STEPS_W'(1)) ? ST_READ : ST_STEP;
        end
      end
      ST_READ: begin
        state_nxt = ST_CAPT;
      end
      ST_CAPT: begin
        if (!out_busy) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_write_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (cmd.cnt_waddr[CADDR_W-1] != cur_r))
    else $error("step write hits the bank being read");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && state_nxt != ST_DRAIN) |-> (!s1_valid_r && !s2_valid_r))
    else $error("step ends with the pipeline still busy");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> s2_valid_r)
    else $error("pipeline stage lost");

  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !out_busy)
    else $error("result captured over a waiting result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !s2_valid_r)
    else $error("initialisation overlaps a step write");

endmodule

[rtl/fixed_length_walk_counter_unit.sv]
// ----------------------------------------------------------------------------
// fixed_length_walk_counter_unit
// Counts walks of an exact length from node 0 to target nodes.
//
// in_chan carries requests. A load request (mode 0) writes one node's yes
// and no successors and its target flag and gives no result. A start
// request (mode 1) carries the walk length and gives one result on
// out_chan: the number of walks of that length from node 0 that end on a
// target node.
// A start request first copies the target flags into a count bank, then
// sweeps the node table once per step (32 reads of the successor memory
// plus a drain of the read pipeline before the banks swap), then fetches
// the count of node 0.
// in_chan.ready is high only between requests; a start holds it low until
// its result is captured, and capture waits while an earlier result waits.
// A finished result waits in an output register while the receiver stalls;
// loads are still taken meanwhile, and a new start runs up to the fetch.
// Reset clears all target flags and the handshake state; successors must
// be loaded before any walk reaches them.
// ----------------------------------------------------------------------------
module fixed_length_walk_counter_unit import flwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  flwc_in_if.sink    in_chan,
  flwc_out_if.source out_chan
);

  flwc_cmd_t          cmd;
  logic [SUCC_W-1:0]  succ_rdata;
  logic [SUCC_W-1:0]  succ_unused;
  logic [COUNT_W-1:0] cnt_rd0, cnt_rd1;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_busy;

  assign out_busy = out_valid_r && !out_chan.ready;

  flwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .succ_rdata (succ_rdata),
    .out_busy   (out_busy),
    .cmd        (cmd)
  );

  flwc_ram #(.WIDTH(SUCC_W), .DEPTH(MAX_NODES)) u_succ_ram (
    .clk   (clk),
    .we    (cmd.succ_we),
    .waddr (cmd.succ_waddr),
    .wdata (cmd.succ_wdata),
    .ra0   (cmd.succ_raddr),
    .ra1   (cmd.succ_raddr),
    .rd0   (succ_rdata),
    .rd1   (succ_unused)
  );

  always_comb begin
    if (cmd.cnt_init) begin
      cnt_wdata = COUNT_W'(cmd.init_bit);
    end else begin
      cnt_wdata = (cmd.use0 ? cnt_rd0 : '0) + (cmd.use1 ? cnt_rd1 : '0);
    end
  end

  flwc_ram #(.WIDTH(COUNT_W), .DEPTH(CDEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cmd.cnt_we),
    .waddr (cmd.cnt_waddr),
    .wdata (cnt_wdata),
    .ra0   (cmd.cnt_ra0),
    .ra1   (cmd.cnt_ra1),
    .rd0   (cnt_rd0),
    .rd1   (cnt_rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_count_r <= cnt_rd0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.walk_count = out_count_r;

endmodule
